// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the torus vertex generator RTL.
// Empty bodies when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define TVG_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("tvg check failed");
`define TVG_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error("tvg bad state");
`else
`define TVG_ASSERT(lbl, clk, rst, prop)
`define TVG_NEVER(lbl, clk, rst, expr)
`endif
`endif

// ===== rtl/tvg_pkg.sv =====
// Package for the torus vertex generator: widths, register codes,
// polynomial coefficients and rounding/saturation helpers. No dependencies.
`default_nettype none
package tvg_pkg;

  localparam int MAX_SEGMENTS = 255;
  localparam int FRAC_BITS    = 16;

  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  localparam logic [30:0] COEF1   = 31'd1686629713;
  localparam logic [30:0] COEF3   = 31'd693598668;
  localparam logic [30:0] COEF5   = 31'd85569306;
  localparam logic [30:0] COEF7   = 31'd5026995;
  localparam logic [30:0] COEF9   = 31'd172272;

  typedef enum logic [2:0] {
    REG_MAJOR_RADIUS   = 3'd0,
    REG_MINOR_RADIUS   = 3'd1,
    REG_MAJOR_SEGMENTS = 3'd2,
    REG_MINOR_SEGMENTS = 3'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [16:0] tex_u;
    logic [16:0] tex_v;
    logic [15:0] base;
    logic        qv;
    logic [1:0]  quad_p;
    logic [1:0]  quad_t;
  } side_t;

  function automatic logic signed [65:0] round_shift(input logic signed [65:0] v,
                                                      input int s);
    logic signed [65:0] half;
    logic signed [65:0] mag;
    half = 66'sd1 <<< (s - 1);
    if (v >= 0) begin
      round_shift = (v + half) >>> s;
    end else begin
      mag = (-v + half) >>> s;
      round_shift = -mag;
    end
  endfunction

  function automatic logic [15:0] sat16(input logic signed [65:0] v);
    if (v > 66'sd32767) begin
      sat16 = 16'h7fff;
    end else if (v < -66'sd32768) begin
      sat16 = 16'h8000;
    end else begin
      sat16 = v[15:0];
    end
  endfunction

  function automatic logic [25:0] sat26(input logic signed [65:0] v);
    if (v > 66'sd33554431) begin
      sat26 = 26'h1ff_ffff;
    end else if (v < -66'sd33554432) begin
      sat26 = 26'h200_0000;
    end else begin
      sat26 = v[25:0];
    end
  endfunction

endpackage
`default_nettype wire

// ===== rtl/tvg_qsine.sv =====
// Six-stage quarter-wave sine, sin(pi/2*r) for r in Q30, result Q30.
// Depends on tvg_pkg for the odd polynomial coefficients.
`default_nettype none
module tvg_qsine (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [30:0] r_in,
  output logic      [31:0] sin_out
);

  logic [30:0] r_d [5];
  logic [30:0] r2;
  logic [30:0] r2_d [3];
  logic [30:0] t7, t5, t3, t1;
  logic [61:0] p_r2, p7, p5, p3, p1, pa;

  assign p_r2 = r_in * r_in;
  assign p7   = r2 * tvg_pkg::COEF9;
  assign p5   = r2_d[0] * t7;
  assign p3   = r2_d[1] * t5;
  assign p1   = r2_d[2] * t3;
  assign pa   = r_d[4] * t1;

  always_ff @(posedge clk) begin
    if (en) begin
      r2      <= p_r2[60:30];
      r_d[0]  <= r_in;
      t7      <= tvg_pkg::COEF7 - p7[60:30];
      r2_d[0] <= r2;
      r_d[1]  <= r_d[0];
      t5      <= tvg_pkg::COEF5 - p5[60:30];
      r2_d[1] <= r2_d[0];
      r_d[2]  <= r_d[1];
      t3      <= tvg_pkg::COEF3 - p3[60:30];
      r2_d[2] <= r2_d[1];
      r_d[3]  <= r_d[2];
      t1      <= tvg_pkg::COEF1 - p1[60:30];
      r_d[4]  <= r_d[3];
      sin_out <= pa[61:30];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/torus_vertex_generator.sv =====
// Torus vertex generator.
// Channels: input items (ring_index, tube_index) on in_valid/in_ready,
// result items on out_valid/out_ready, register writes on cfg_valid/
// cfg_ready with cfg_index and cfg_data (cfg_ready is always high).
// Registers: 0 major_radius, 1 minor_radius, 2 major_segments,
// 3 minor_segments; other indexes are ignored. Write them only while idle.
// Throughput: one item per cycle while out_ready is high or the output
// stage is empty; the sine polynomial and the position multiplies are
// split over a 14-deep register pipeline.
// Reset clears all valid bits and loads radii 1.0 and 0.25, segments 32
// and 16. When the receiver stalls, the whole pipeline holds and in_ready
// falls in the same cycle; nothing is lost or repeated, and a pipeline
// with bubbles keeps accepting until its output stage holds an item.
// Depends on tvg_pkg, tvg_qsine and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module torus_vertex_generator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  ring_index,
  input  wire logic [7:0]  tube_index,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [25:0]      pos_x,
  output logic [25:0]      pos_y,
  output logic [25:0]      pos_z,
  output logic [15:0]      normal_x,
  output logic [15:0]      normal_y,
  output logic [15:0]      normal_z,
  output logic [15:0]      tangent_x,
  output logic [15:0]      tangent_z,
  output logic [16:0]      tex_u,
  output logic [16:0]      tex_v,
  output logic [15:0]      quad_base_index,
  output logic             quad_valid,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);

  localparam logic [63:0] P32 = 64'd1 << 32;
  localparam logic [63:0] P16 = 64'd1 << tvg_pkg::FRAC_BITS;
  localparam logic [63:0] P25 = 64'd1 << 25;

  logic [31:0] rc32_tab [256];
  logic [7:0]  rm32_tab [256];
  logic [16:0] rc16_tab [256];
  logic [7:0]  rm16_tab [256];
  logic [23:0] m25_tab  [256];

  for (genvar g = 0; g < 256; g++) begin : g_tab
    if (g < 3) begin : g_low
      assign rc32_tab[g] = '0;
      assign rm32_tab[g] = '0;
      assign rc16_tab[g] = '0;
      assign rm16_tab[g] = '0;
      assign m25_tab[g]  = '0;
    end else begin : g_ent
      localparam logic [63:0] RC32 = P32 / g;
      localparam logic [63:0] RM32 = P32 % g;
      localparam logic [63:0] RC16 = P16 / g;
      localparam logic [63:0] RM16 = P16 % g;
      localparam logic [63:0] M25  = (P25 + g - 1) / g;
      assign rc32_tab[g] = RC32[31:0];
      assign rm32_tab[g] = RM32[7:0];
      assign rc16_tab[g] = RC16[16:0];
      assign rm16_tab[g] = RM16[7:0];
      assign m25_tab[g]  = M25[23:0];
    end
  end

  logic [23:0] major_radius, minor_radius;
  logic [7:0]  major_segments, minor_segments;
  logic [7:0]  nmaj, nmin;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      major_radius   <= 24'd65536;
      minor_radius   <= 24'd16384;
      major_segments <= 8'd32;
      minor_segments <= 8'd16;
    end else if (cfg_valid) begin
      unique case (tvg_pkg::cfg_reg_t'(cfg_index))
        tvg_pkg::REG_MAJOR_RADIUS:   major_radius   <= cfg_data;
        tvg_pkg::REG_MINOR_RADIUS:   minor_radius   <= cfg_data;
        tvg_pkg::REG_MAJOR_SEGMENTS: major_segments <= cfg_data[7:0];
        tvg_pkg::REG_MINOR_SEGMENTS: minor_segments <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign nmaj = (major_segments < 8'd3) ? 8'd3 : major_segments;
  assign nmin = (minor_segments < 8'd3) ? 8'd3 : minor_segments;

  logic [1:14] vld;
  logic        adv;

  assign adv       = ~vld[14] | out_ready;
  assign in_ready  = adv;
  assign out_valid = vld[14];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {in_valid, vld[1:13]};
    end
  end

  // stage 1: clamp indices, split the turn fraction into whole and remainder parts
  logic [7:0]  ic, jc;
  logic [31:0] s1_pp, s1_pt;
  logic [15:0] s1_xp, s1_xt, s1_yu, s1_yv;
  logic [16:0] s1_uu, s1_uv;
  logic [15:0] s1_base;
  logic        s1_qv;
  logic [39:0] mp, mt;
  logic [24:0] mu, mv;
  logic [16:0] base_w;

  assign ic     = (ring_index > nmaj) ? nmaj : ring_index;
  assign jc     = (tube_index > nmin) ? nmin : tube_index;
  assign mp     = ic * rc32_tab[nmaj];
  assign mt     = jc * rc32_tab[nmin];
  assign mu     = ic * rc16_tab[nmaj];
  assign mv     = jc * rc16_tab[nmin];
  assign base_w = ic * ({1'b0, nmin} + 9'd1) + {9'd0, jc};

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pp   <= mp[31:0];
      s1_pt   <= mt[31:0];
      s1_xp   <= ic * rm32_tab[nmaj] + {9'd0, nmaj[7:1]};
      s1_xt   <= jc * rm32_tab[nmin] + {9'd0, nmin[7:1]};
      s1_uu   <= mu[16:0];
      s1_uv   <= mv[16:0];
      s1_yu   <= ic * rm16_tab[nmaj] + {9'd0, nmaj[7:1]};
      s1_yv   <= jc * rm16_tab[nmin] + {9'd0, nmin[7:1]};
      s1_base <= base_w[15:0];
      s1_qv   <= (ic < nmaj) && (jc < nmin);
    end
  end

  // stage 2: divide the small remainders by reciprocal multiply
  logic [39:0] dp, dt, du, dv;
  logic [8:0]  s2_qp, s2_qt, s2_qu, s2_qv2;
  logic [31:0] s2_pp, s2_pt;
  logic [16:0] s2_uu, s2_uv;
  logic [15:0] s2_base;
  logic        s2_qv;

  assign dp = s1_xp * m25_tab[nmaj];
  assign dt = s1_xt * m25_tab[nmin];
  assign du = s1_yu * m25_tab[nmaj];
  assign dv = s1_yv * m25_tab[nmin];

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_qp   <= dp[33:25];
      s2_qt   <= dt[33:25];
      s2_qu   <= du[33:25];
      s2_qv2  <= dv[33:25];
      s2_pp   <= s1_pp;
      s2_pt   <= s1_pt;
      s2_uu   <= s1_uu;
      s2_uv   <= s1_uv;
      s2_base <= s1_base;
      s2_qv   <= s1_qv;
    end
  end

  // stage 3: phases and uv, then advance the side data
  logic [31:0] ph_p_n, ph_t_n;
  logic [29:0] ph_p, ph_t;
  tvg_pkg::side_t sd [3:14];

  assign ph_p_n = s2_pp + {23'd0, s2_qp};
  assign ph_t_n = s2_pt + {23'd0, s2_qt};

  always_ff @(posedge clk) begin
    if (adv) begin
      ph_p         <= ph_p_n[29:0];
      ph_t         <= ph_t_n[29:0];
      sd[3].tex_u  <= s2_uu + {8'd0, s2_qu};
      sd[3].tex_v  <= s2_uv + {8'd0, s2_qv2};
      sd[3].base   <= s2_base;
      sd[3].qv     <= s2_qv;
      sd[3].quad_p <= ph_p_n[31:30];
      sd[3].quad_t <= ph_t_n[31:30];
      for (int k = 4; k <= 14; k++) begin
        sd[k] <= sd[k-1];
      end
    end
  end

  // stages 4 to 9: four quarter-sine pipelines
  logic [31:0] a_p, b_p, a_t, b_t;

  tvg_qsine u_sin_p (.clk, .en(adv), .r_in({1'b0, ph_p}), .sin_out(a_p));
  tvg_qsine u_cos_p (.clk, .en(adv), .r_in(tvg_pkg::Q30_ONE - {1'b0, ph_p}),
                     .sin_out(b_p));
  tvg_qsine u_sin_t (.clk, .en(adv), .r_in({1'b0, ph_t}), .sin_out(a_t));
  tvg_qsine u_cos_t (.clk, .en(adv), .r_in(tvg_pkg::Q30_ONE - {1'b0, ph_t}),
                     .sin_out(b_t));

  // stage 10: quadrant fold
  logic signed [32:0] sp_n, cp_n, st_n, ct_n;
  logic signed [32:0] sp, cp, st, ct;
  logic signed [32:0] ap_s, bp_s, at_s, bt_s;

  assign ap_s = $signed({1'b0, a_p});
  assign bp_s = $signed({1'b0, b_p});
  assign at_s = $signed({1'b0, a_t});
  assign bt_s = $signed({1'b0, b_t});

  always_comb begin
    unique case (sd[9].quad_p)
      2'd0: begin sp_n = ap_s;  cp_n = bp_s;  end
      2'd1: begin sp_n = bp_s;  cp_n = -ap_s; end
      2'd2: begin sp_n = -ap_s; cp_n = -bp_s; end
      default: begin sp_n = -bp_s; cp_n = ap_s; end
    endcase
    unique case (sd[9].quad_t)
      2'd0: begin st_n = at_s;  ct_n = bt_s;  end
      2'd1: begin st_n = bt_s;  ct_n = -at_s; end
      2'd2: begin st_n = -at_s; ct_n = -bt_s; end
      default: begin st_n = -bt_s; ct_n = at_s; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sp <= sp_n;
      cp <= cp_n;
      st <= st_n;
      ct <= ct_n;
    end
  end

  // stage 11: tube products and normal products
  logic signed [24:0] rmin_s;
  logic signed [57:0] prc, prs;
  logic signed [65:0] pnx, pnz;
  logic signed [32:0] sp11, cp11;
  logic [15:0] ny11, tx11, tz11;

  assign rmin_s = $signed({1'b0, minor_radius});

  always_ff @(posedge clk) begin
    if (adv) begin
      prc  <= rmin_s * ct;
      prs  <= rmin_s * st;
      pnx  <= ct * cp;
      pnz  <= ct * sp;
      sp11 <= sp;
      cp11 <= cp;
      ny11 <= tvg_pkg::sat16(tvg_pkg::round_shift(66'(st), 15));
      tx11 <= tvg_pkg::sat16(tvg_pkg::round_shift(66'(-sp), 15));
      tz11 <= tvg_pkg::sat16(tvg_pkg::round_shift(66'(cp), 15));
    end
  end

  // stage 12: ring distance, y and normals
  logic signed [26:0] ring_dist;
  logic signed [65:0] rc_rnd;
  logic signed [32:0] sp12, cp12;
  logic [25:0] py12;
  logic [15:0] nx12, ny12, nz12, tx12, tz12;

  assign rc_rnd = tvg_pkg::round_shift(66'(prc), 30);

  always_ff @(posedge clk) begin
    if (adv) begin
      ring_dist <= $signed({3'd0, major_radius}) + rc_rnd[26:0];
      py12 <= tvg_pkg::sat26(tvg_pkg::round_shift(66'(prs), 30));
      nx12 <= tvg_pkg::sat16(tvg_pkg::round_shift(pnx, 45));
      nz12 <= tvg_pkg::sat16(tvg_pkg::round_shift(pnz, 45));
      ny12 <= ny11;
      tx12 <= tx11;
      tz12 <= tz11;
      sp12 <= sp11;
      cp12 <= cp11;
    end
  end

  // stage 13: ring products
  logic signed [59:0] pxp, pzp;
  logic [25:0] py13;
  logic [15:0] nx13, ny13, nz13, tx13, tz13;

  always_ff @(posedge clk) begin
    if (adv) begin
      pxp  <= ring_dist * cp12;
      pzp  <= ring_dist * sp12;
      py13 <= py12;
      nx13 <= nx12;
      ny13 <= ny12;
      nz13 <= nz12;
      tx13 <= tx12;
      tz13 <= tz12;
    end
  end

  // stage 14: output register
  always_ff @(posedge clk) begin
    if (adv) begin
      pos_x     <= tvg_pkg::sat26(tvg_pkg::round_shift(66'(pxp), 30));
      pos_z     <= tvg_pkg::sat26(tvg_pkg::round_shift(66'(pzp), 30));
      pos_y     <= py13;
      normal_x  <= nx13;
      normal_y  <= ny13;
      normal_z  <= nz13;
      tangent_x <= tx13;
      tangent_z <= tz13;
    end
  end

  assign tex_u           = sd[14].tex_u;
  assign tex_v           = sd[14].tex_v;
  assign quad_base_index = sd[14].base;
  assign quad_valid      = sd[14].qv;

  `TVG_ASSERT(a_hold_on_stall, clk, rst, !adv |=> $stable(vld))
  `TVG_NEVER(a_zero_vector, clk, rst, vld[10] && (sp == 0) && (cp == 0))
  `TVG_NEVER(a_quad_uv_edge, clk, rst, out_valid && quad_valid && (tex_u == 17'h10000 || tex_v == 17'h10000))

endmodule
`default_nettype wire
